// ===== hw/rtl/aht_pkg.sv =====
// shared types, constants and helper functions for the allocation tracking hash table
package aht_pkg;

   localparam int TABLE_SLOTS = 1024;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int SLOT_OUT_W = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

   localparam logic [1:0] KIND_STORE = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [2:0] ST_STORED_HOME   = 3'd0;
   localparam logic [2:0] ST_STORED_PROBED = 3'd1;
   localparam logic [2:0] ST_FULL          = 3'd2;
   localparam logic [2:0] ST_FREED_HOME    = 3'd3;
   localparam logic [2:0] ST_FREED_PROBED  = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND     = 3'd5;
   localparam logic [2:0] ST_IGNORED       = 3'd6;
   localparam logic [2:0] ST_CLEARED       = 3'd7;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_FREE,
      OP_CLEAR,
      OP_IGNORE
   } aht_op_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_WAIT,
      S_CHECK,
      S_CLEAR
   } aht_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] address;
      logic [31:0] source_line;
      logic [15:0] source_file_tag;
      logic [31:0] size_bytes;
   } aht_req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [31:0]           full_count;
      logic [31:0]           not_found_count;
      logic [31:0]           hit_count;
      logic [31:0]           miss_count;
      logic [31:0]           store_count;
   } aht_rsp_type;

   typedef struct packed {
      aht_op_type  op;
      logic [63:0] address;
      logic [31:0] source_line;
      logic [15:0] source_file_tag;
      logic [31:0] size_bytes;
   } aht_cmd_type;

   typedef struct packed {
      logic        valid;
      aht_cmd_type cmd;
   } aht_head_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } aht_back_status_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
      return (i == LAST_SLOT) ? '0 : i + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_W-1:0] home_slot(input logic [63:0] a);
      return SLOT_W'(a % TABLE_SLOTS);
   endfunction

endpackage

// ===== hw/rtl/allocation_tracking_hash_table.sv =====
// allocation tracking hash table top level: front end and probe engine
// a store or free takes a wait and a check state per probed slot, then a result
// the engine takes one word at a time
// clear walks every slot, an ignored word skips probing; a 2-word queue feeds the engine
// after reset a clearing pass over every slot runs with busy high, enable resets to 0
// results are strobed for one cycle and the receiver cannot stall
module allocation_tracking_hash_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  aht_pkg::aht_req_type req,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data,
   output logic                 rsp_strobe,
   output aht_pkg::aht_rsp_type rsp
);
   import aht_pkg::*;

   aht_head_type        head;
   aht_back_status_type back_status;

   aht_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .back_status (back_status),
      .head        (head)
   );

   aht_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .back_status (back_status),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp)
   );

endmodule

// ===== hw/rtl/aht_front.sv =====
// request front end: config register, classification and command queue
module aht_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  aht_pkg::aht_req_type         req,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_data,
   input  aht_pkg::aht_back_status_type back_status,
   output aht_pkg::aht_head_type        head
);
   import aht_pkg::*;

   logic                   enabled_ff;
   aht_cmd_type            q_ff [QUEUE_DEPTH];
   logic [QCNT_W-1:0]      cnt_ff;
   logic [QCNT_W-1:0]      cnt_in;
   aht_cmd_type            cmd;
   logic                   push;
   logic                   pop;

   assign csr_ready = 1'b1;
   assign busy = (cnt_ff == QCNT_W'(QUEUE_DEPTH)) || back_status.init_busy;
   assign push = start && !busy;
   assign pop = back_status.pop;

   always_comb begin
      cmd.address = req.address;
      cmd.source_line = req.source_line;
      cmd.source_file_tag = req.source_file_tag;
      cmd.size_bytes = req.size_bytes;
      if (!enabled_ff) begin
         cmd.op = OP_IGNORE;
      end else begin
         unique case (req.kind)
            KIND_STORE: cmd.op = OP_STORE;
            KIND_FREE:  cmd.op = OP_FREE;
            KIND_CLEAR: cmd.op = OP_CLEAR;
            default:    cmd.op = OP_IGNORE;
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign head.valid = (cnt_ff != '0);
   assign head.cmd = q_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            enabled_ff <= csr_data;
         end
         cnt_ff <= cnt_in;
      end
   end

   // shift queue, entry 0 is the head
   always_ff @(posedge clock) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (pop) begin
            if (push && (cnt_ff == QCNT_W'(k + 1))) begin
               q_ff[k] <= cmd;
            end else if (k < QUEUE_DEPTH - 1) begin
               q_ff[k] <= q_ff[k + 1];
            end
         end else if (push && (cnt_ff == QCNT_W'(k))) begin
            q_ff[k] <= cmd;
         end
      end
   end

endmodule

// ===== hw/rtl/aht_back.sv =====
// probe engine: slot memories, linear probe sequencer, counters and result register
module aht_back (
   input  logic                         clock,
   input  logic                         reset,
   input  aht_pkg::aht_head_type        head,
   output aht_pkg::aht_back_status_type back_status,
   output logic                         rsp_strobe,
   output aht_pkg::aht_rsp_type         rsp
);
   import aht_pkg::*;

   typedef struct packed {
      logic        valid;
      logic [63:0] address;
   } aht_rec_type;

   typedef struct packed {
      logic [31:0] line;
      logic [15:0] tag;
      logic [31:0] bytes;
   } aht_pay_type;

   aht_rec_type   rec_mem [TABLE_SLOTS];
   aht_pay_type   pay_mem [TABLE_SLOTS];

   aht_state_type state_ff, state_in;
   aht_cmd_type   cmd_ff, cmd_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   aht_rec_type   rd_ff;
   logic [31:0]   full_ff, full_in;
   logic [31:0]   nf_ff, nf_in;
   logic [31:0]   hit_ff, hit_in;
   logic [31:0]   miss_ff, miss_in;
   logic [31:0]   store_ff, store_in;
   aht_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pop;
   logic          we;
   aht_rec_type   wr_rec;
   logic          pay_we;
   logic          found;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      full_in = full_ff;
      nf_in = nf_ff;
      hit_in = hit_ff;
      miss_in = miss_ff;
      store_in = store_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      pop = 1'b0;
      we = 1'b0;
      wr_rec.valid = 1'b0;
      wr_rec.address = cmd_ff.address;
      pay_we = 1'b0;
      found = (cmd_ff.op == OP_STORE) ? !rd_ff.valid
                                      : (rd_ff.valid && (rd_ff.address == cmd_ff.address));
      unique case (state_ff)
         S_INIT: begin
            we = 1'b1;
            idx_in = next_slot(idx_ff);
            if (idx_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               cmd_in = head.cmd;
               idx_in = home_slot(head.cmd.address);
               cnt_in = '0;
               unique case (head.cmd.op)
                  OP_IGNORE: begin
                     rsp_in.status = ST_IGNORED;
                     rsp_in.slot = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_CLEAR: begin
                     idx_in = '0;
                     state_in = S_CLEAR;
                  end
                  OP_STORE, OP_FREE: begin
                     state_in = S_WAIT;
                  end
               endcase
            end
         end
         S_WAIT: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (found) begin
               we = 1'b1;
               wr_rec.valid = (cmd_ff.op == OP_STORE);
               pay_we = (cmd_ff.op == OP_STORE);
               rsp_in.slot = SLOT_OUT_W'(idx_ff);
               if (cnt_ff == '0) begin
                  hit_in = sat_inc(hit_ff);
                  rsp_in.status = (cmd_ff.op == OP_STORE) ? ST_STORED_HOME : ST_FREED_HOME;
               end else begin
                  miss_in = sat_inc(miss_ff);
                  rsp_in.status = (cmd_ff.op == OP_STORE) ? ST_STORED_PROBED : ST_FREED_PROBED;
               end
               if (cmd_ff.op == OP_STORE) begin
                  store_in = sat_inc(store_ff);
               end
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (cnt_ff == LAST_SLOT) begin
               rsp_in.slot = '0;
               if (cmd_ff.op == OP_STORE) begin
                  full_in = sat_inc(full_ff);
                  store_in = sat_inc(store_ff);
                  rsp_in.status = ST_FULL;
               end else begin
                  nf_in = sat_inc(nf_ff);
                  rsp_in.status = ST_NOT_FOUND;
               end
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in = next_slot(idx_ff);
               cnt_in = cnt_ff + SLOT_W'(1);
               state_in = S_WAIT;
            end
         end
         S_CLEAR: begin
            we = 1'b1;
            idx_in = next_slot(idx_ff);
            if (idx_ff == LAST_SLOT) begin
               rsp_in.status = ST_CLEARED;
               rsp_in.slot = '0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_in.full_count = full_in;
      rsp_in.not_found_count = nf_in;
      rsp_in.hit_count = hit_in;
      rsp_in.miss_count = miss_in;
      rsp_in.store_count = store_in;
   end

   assign back_status.pop = pop;
   assign back_status.init_busy = (state_ff == S_INIT);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         idx_ff <= '0;
         cnt_ff <= '0;
         full_ff <= '0;
         nf_ff <= '0;
         hit_ff <= '0;
         miss_ff <= '0;
         store_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         full_ff <= full_in;
         nf_ff <= nf_in;
         hit_ff <= hit_in;
         miss_ff <= miss_in;
         store_ff <= store_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         rec_mem[idx_ff] <= wr_rec;
      end
      rd_ff <= rec_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[idx_ff] <= '{line: cmd_ff.source_line, tag: cmd_ff.source_file_tag,
                              bytes: cmd_ff.size_bytes};
      end
   end

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !rsp_valid_ff)
      else $error("result during init clear");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head.valid && (state_ff == S_IDLE)))
      else $error("pop without queued word");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_ff.status == ST_FULL) || (rsp_ff.status == ST_NOT_FOUND)
                        || (rsp_ff.status == ST_IGNORED) || (rsp_ff.status == ST_CLEARED)))
      |-> (rsp_ff.slot == '0))
      else $error("nonzero slot on failed word");

   a_store_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INIT) |=> (store_ff >= $past(store_ff)))
      else $error("store counter went down");

endmodule
